FILE: design/ies_pkg.sv
// Shared types and constants for the incidence edge store.
// Used by the controller, the datapath and the top level; depends on nothing.
package ies_pkg;

    // Table sizes
    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 256;

    // Field widths
    localparam int REQ_W       = 2;
    localparam int VERT_W      = 6;
    localparam int WEIGHT_W    = 16;
    localparam int MAG_W       = WEIGHT_W - 1;
    localparam int STATUS_W    = 2;
    localparam int VCOUNT_W    = 7;
    localparam int EDGE_ADDR_W = $clog2(MAX_EDGES);
    localparam int EDGE_CNT_W  = $clog2(MAX_EDGES + 1);
    localparam int ENTRY_W     = 2 * VERT_W + WEIGHT_W;
    localparam int S_TDATA_W   = ((2 * VERT_W + WEIGHT_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((WEIGHT_W + 7) / 8) * 8;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = VCOUNT_W'(64);

    // Request codes
    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MIN   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BADV = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic start;   // latch the request, clear the scan
        logic step;    // read the next edge entry
        logic finish;  // commit the result, append on a successful add
    } ies_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_scan;  // request must look through the stored edges
        logic scan_end;   // every stored edge has been read
        logic out_free;   // output register can take a result now
    } ies_sts_t;

endpackage

FILE: design/incidence_edge_store.sv
// Incidence edge store: an undirected weighted graph held as a list of edge
// columns (start vertex, end vertex, weight). Each transaction on the slave
// side is one request (add, query or minimum) and gives exactly one result
// transaction on the master side. A request that must look at the stored
// edges reads the edge memory one entry per cycle through its single read
// port; a request rejected without a scan (invalid vertex, self-pair, unused
// code) skips the scan. A result waits in an output register, so the next
// request is accepted while the previous result is still unclaimed. The
// user must write vertex_count through cfg_we/cfg_wdata only while no
// request is in flight; the block itself does not enforce this.
// Depends on ies_pkg, ies_ctrl, ies_datapath and ies_ram.
module incidence_edge_store (
    input  logic                               clk,
    input  logic                               rst_n,
    // Requests
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ies_pkg::S_TDATA_W-1:0]      s_tdata,   // vertex_a, vertex_b, edge_weight
    input  logic [ies_pkg::REQ_W-1:0]          s_tuser,   // req_type
    // Results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ies_pkg::M_TDATA_W-1:0]      m_tdata,   // result_value
    output logic [ies_pkg::STATUS_W-1:0]       m_tuser,   // status
    // Configuration
    input  logic                               cfg_we,
    input  logic [ies_pkg::VCOUNT_W-1:0]       cfg_wdata  // vertex_count
);
    import ies_pkg::*;

    ies_cmd_t cmd;
    ies_sts_t sts;

    ies_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ies_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: design/ies_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the edge entries of the incidence edge store.
module ies_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/ies_ctrl.sv
// Request sequencer of the incidence edge store: accept, scan, commit.
// Depends on ies_pkg for the command and status structs.
module ies_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  ies_pkg::ies_sts_t sts,
    output ies_pkg::ies_cmd_t cmd
);
    import ies_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                state_next = sts.need_scan ? S_SCAN : S_DONE;
            end
            S_SCAN:
            begin
                if (sts.scan_end)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_DONE:
            begin
                // Hold until the output register has room
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Commands are mutually exclusive
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.start, cmd.step, cmd.finish}))
        else $error("ies_ctrl: overlapping commands");

    // A finished request always returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> s_tready)
        else $error("ies_ctrl: not idle after finish");

    // Accepting a transaction always leaves idle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> !s_tready)
        else $error("ies_ctrl: still idle after accept");

endmodule

FILE: design/ies_datapath.sv
// Datapath of the incidence edge store: request latch, edge memory, scan
// counter, match and minimum accumulators, result register.
// Depends on ies_pkg and ies_ram.
module ies_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [ies_pkg::REQ_W-1:0]           s_tuser,
    input  logic [ies_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic                                cfg_we,
    input  logic [ies_pkg::VCOUNT_W-1:0]        cfg_wdata,
    input  ies_pkg::ies_cmd_t                   cmd,
    output ies_pkg::ies_sts_t                   sts,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ies_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic [ies_pkg::STATUS_W-1:0]        m_tuser
);
    import ies_pkg::*;

    // Request latch
    logic [REQ_W-1:0]           req_reg;
    logic [VERT_W-1:0]          a_reg;
    logic [VERT_W-1:0]          b_reg;
    logic signed [WEIGHT_W-1:0] w_reg;
    logic signed [WEIGHT_W-1:0] in_w;
    logic signed [WEIGHT_W-1:0] in_w_clamped;

    // Configuration and table state
    logic [VCOUNT_W-1:0]   vcount_reg;
    logic [EDGE_CNT_W-1:0] count_reg;
    logic [EDGE_CNT_W-1:0] idx_reg;
    logic                  rd_valid_reg;

    // Scan accumulators
    logic                       found_reg;
    logic signed [WEIGHT_W-1:0] found_val_reg;
    logic [MAG_W-1:0]           best_reg;

    // Result register
    logic                       out_valid_reg;
    logic signed [WEIGHT_W-1:0] out_value_reg;
    logic [STATUS_W-1:0]        out_status_reg;

    // Memory signals
    logic [ENTRY_W-1:0]         rd_entry;
    logic [ENTRY_W-1:0]         wr_entry;
    logic                       mem_we;
    logic [VERT_W-1:0]          rd_from;
    logic [VERT_W-1:0]          rd_to;
    logic signed [WEIGHT_W-1:0] rd_val;
    logic signed [WEIGHT_W-1:0] rd_neg;
    logic [MAG_W-1:0]           rd_mag;
    logic                       fwd_hit;
    logic                       rev_hit;

    // Decisions
    logic                       a_ok;
    logic                       b_ok;
    logic                       same_ab;
    logic                       table_full;
    logic                       need_scan;
    logic                       add_ok;
    logic [STATUS_W-1:0]        res_status;
    logic signed [WEIGHT_W-1:0] res_value;

    // Clamp the most negative weight so its negation fits
    assign in_w         = s_tdata[2*VERT_W +: WEIGHT_W];
    assign in_w_clamped = (in_w == {1'b1, {(WEIGHT_W-1){1'b0}}})
                        ? {1'b1, {(WEIGHT_W-2){1'b0}}, 1'b1} : in_w;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            req_reg <= s_tuser;
            a_reg   <= s_tdata[VERT_W-1:0];
            b_reg   <= s_tdata[VERT_W +: VERT_W];
            w_reg   <= in_w_clamped;
        end
    end

    // Vertex range checks
    assign a_ok = ({1'b0, a_reg} < vcount_reg)
               && ({1'b0, a_reg} < VCOUNT_W'(MAX_VERTICES));
    assign b_ok = ({1'b0, b_reg} < vcount_reg)
               && ({1'b0, b_reg} < VCOUNT_W'(MAX_VERTICES));
    assign same_ab    = (a_reg == b_reg);
    assign table_full = (count_reg >= EDGE_CNT_W'(MAX_EDGES));

    always_comb
    begin
        unique case (req_reg) inside
            REQ_ADD, REQ_QUERY: need_scan = a_ok && b_ok && !same_ab;
            REQ_MIN:            need_scan = a_ok;
            default:            need_scan = 1'b0;
        endcase
    end
    assign sts.need_scan = need_scan;
    assign sts.scan_end  = (idx_reg == count_reg);
    assign sts.out_free  = !out_valid_reg || m_tready;

    // Edge memory: one entry per stored edge
    assign wr_entry = {w_reg, b_reg, a_reg};

    ies_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[EDGE_ADDR_W-1:0]),
        .wdata (wr_entry),
        .re    (cmd.step),
        .raddr (idx_reg[EDGE_ADDR_W-1:0]),
        .rdata (rd_entry)
    );

    // Entry decode and compare
    assign rd_from = rd_entry[VERT_W-1:0];
    assign rd_to   = rd_entry[VERT_W +: VERT_W];
    assign rd_val  = rd_entry[2*VERT_W +: WEIGHT_W];
    assign rd_neg  = -rd_val;
    assign rd_mag  = rd_val[WEIGHT_W-1] ? rd_neg[MAG_W-1:0] : rd_val[MAG_W-1:0];
    assign fwd_hit = (rd_from == a_reg) && (rd_to == b_reg);
    assign rev_hit = (rd_from == b_reg) && (rd_to == a_reg);

    // Scan counter and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.step;
            if (cmd.start)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.step)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (rd_valid_reg && (rd_val != '0) && (fwd_hit || rev_hit) && !found_reg)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            best_reg <= '0;
        end
        else if (rd_valid_reg)
        begin
            // Keep the first nonzero match in either direction
            if ((rd_val != '0) && (fwd_hit || rev_hit) && !found_reg)
            begin
                found_val_reg <= fwd_hit ? rd_val : rd_neg;
            end
            // Track the smallest nonzero magnitude at vertex a
            if (((rd_from == a_reg) || (rd_to == a_reg)) && (rd_mag != '0)
                && ((best_reg == '0) || (rd_mag < best_reg)))
            begin
                best_reg <= rd_mag;
            end
        end
    end

    // Result selection
    always_comb
    begin
        res_status = STAT_MISS;
        res_value  = '0;
        add_ok     = 1'b0;
        unique case (req_reg)
            REQ_ADD:
            begin
                if (!a_ok || !b_ok)
                begin
                    res_status = STAT_BADV;
                end
                else if (same_ab || found_reg)
                begin
                    res_status = STAT_MISS;
                end
                else if (table_full)
                begin
                    res_status = STAT_FULL;
                end
                else
                begin
                    res_status = STAT_OK;
                    add_ok     = 1'b1;
                end
            end
            REQ_QUERY:
            begin
                if (!a_ok || !b_ok)
                begin
                    res_status = STAT_BADV;
                end
                else if (found_reg)
                begin
                    res_status = STAT_OK;
                    res_value  = found_val_reg;
                end
            end
            REQ_MIN:
            begin
                if (!a_ok)
                begin
                    res_status = STAT_BADV;
                end
                else if (best_reg != '0)
                begin
                    res_status = STAT_OK;
                    res_value  = {1'b0, best_reg};
                end
            end
            default:
            begin
                res_status = STAT_MISS;
            end
        endcase
    end

    assign mem_we = cmd.finish && add_ok;

    // Vertex count register and edge count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= VCOUNT_RESET;
            count_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                vcount_reg <= cfg_wdata;
            end
            if (mem_we)
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_value_reg  <= res_value;
            out_status_reg <= res_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_value_reg);
    assign m_tuser  = out_status_reg;

    // Scan never passes the stored edges
    assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= count_reg)
        else $error("ies_datapath: scan index beyond edge count");

    // Edge count stays within the table
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= EDGE_CNT_W'(MAX_EDGES))
        else $error("ies_datapath: edge count overflow");

    // Edge count only ever grows by one, on a committed add
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ((count_reg == $past(count_reg) + 1'b1) && $past(mem_we)))
        else $error("ies_datapath: edge count changed without an add");

    // A result is never overwritten before it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || m_tready))
        else $error("ies_datapath: result overwritten");

endmodule
